/* design/gpr_pkg.sv */
// gpr_pkg: shared types, register offsets and decode helpers for the gpio port register block
// no dependencies; used by the interfaces, the store, the execute stage and the top level
package gpr_pkg;

  localparam int unsigned WORDS     = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MAX_PORTS = 4;

  // bus window and per-port register offsets
  localparam logic [11:0] WINDOW_SIZE    = 12'h400;
  localparam logic [7:0]  REG_PIN        = 8'h00;
  localparam logic [7:0]  REG_DATS       = 8'h14;
  localparam logic [7:0]  REG_IM         = 8'h20;
  localparam logic [7:0]  REG_ALIAS_LAST = 8'h78;
  localparam logic [7:0]  REG_FLG        = 8'h80;
  localparam logic [3:0]  ALIAS_SET_NIB  = 4'h4;
  localparam logic [3:0]  ALIAS_CLR_NIB  = 4'h8;

  localparam logic [DATA_W-1:0] ALL_ONES  = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00ff;
  localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_ffff;

  // request kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PIN   = 2'd2,
    KIND_FLAG  = 2'd3
  } kind_t;

  // access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef struct packed {
    kind_t              kind;
    logic [11:0]        offset;
    logic [1:0]         size_code;
    logic [DATA_W-1:0]  write_data;
    logic [1:0]         port;
    logic [DATA_W-1:0]  pin_mask;
    logic               level_high;
    logic               flag_on_change;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  // register offset within a port, word aligned
  function automatic logic [7:0] reg_of(input logic [11:0] offset);
    reg_of = {offset[7:2], 2'b00};
  endfunction

  // set/clear alias words: 0x14..0x78 with low nibble 4 or 8
  function automatic logic is_alias(input logic [11:0] offset);
    logic [7:0] rg;
    rg = reg_of(offset);
    is_alias = (rg >= REG_DATS) && (rg <= REG_ALIAS_LAST) &&
               ((rg[3:0] == ALIAS_SET_NIB) || (rg[3:0] == ALIAS_CLR_NIB));
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr(input logic [11:0] offset);
    word_addr = offset[9:2];
  endfunction

  // canonical word of an alias: same port, low nibble cleared
  function automatic logic [ADDR_W-1:0] canon_addr(input logic [11:0] offset);
    canon_addr = {offset[9:8], offset[7:4], 2'b00};
  endfunction

  // store word touched by a request
  function automatic logic [ADDR_W-1:0] store_addr(input kind_t kind,
                                                   input logic [11:0] offset);
    if (kind == KIND_WRITE && is_alias(offset)) begin
      store_addr = canon_addr(offset);
    end else begin
      store_addr = word_addr(offset);
    end
  endfunction

endpackage

/* design/gpr_if.sv */
// gpr_if: request, result and configuration channel interfaces
// depends on gpr_pkg for data widths
interface gpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] offset;
  logic [1:0]  size_code;
  logic [31:0] write_data;
  logic [1:0]  port;
  logic [31:0] pin_mask;
  logic        level_high;
  logic        flag_on_change;

  modport source (output valid, kind, offset, size_code, write_data, port, pin_mask,
                  level_high, flag_on_change, input ready);
  modport sink (input valid, kind, offset, size_code, write_data, port, pin_mask,
                level_high, flag_on_change, output ready);
endinterface

interface gpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gpr_pkg::DATA_W-1:0]  read_data;
  logic [3:0]                  irq_lines;
  logic                        level_changed;

  modport source (output valid, read_data, irq_lines, level_changed, input ready);
  modport sink (input valid, read_data, irq_lines, level_changed, output ready);
endinterface

interface gpr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  index;
  logic [gpr_pkg::DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/gpr_store.sv */
// gpr_store: 256 x 32 register store, one write and one registered read port
// depends on gpr_pkg; per-word valid bits give the reset image without a clearing pass
module gpr_store #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [gpr_pkg::ADDR_W-1:0]   rd_addr,
  input  gpr_pkg::store_wr_t           wr,
  output logic [gpr_pkg::DATA_W-1:0]   rd_data
);

  logic [gpr_pkg::DATA_W-1:0] mem [gpr_pkg::WORDS];
  logic [gpr_pkg::WORDS-1:0]  vld_r;
  logic [gpr_pkg::DATA_W-1:0] mem_q_r;
  logic [gpr_pkg::DATA_W-1:0] dflt_r;
  logic [gpr_pkg::DATA_W-1:0] byp_data_r;
  logic                       byp_r;
  logic                       vld_q_r;
  logic [gpr_pkg::DATA_W-1:0] dflt_nxt;

  // reset image: interrupt mask words of present ports are all ones
  always_comb begin
    dflt_nxt = '0;
    if (rd_addr[5:0] == gpr_pkg::REG_IM[7:2] && {1'b0, rd_addr[7:6]} < 3'(NUM_PORTS)) begin
      dflt_nxt = gpr_pkg::ALL_ONES;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      dflt_r     <= dflt_nxt;
      byp_data_r <= wr.data;
    end
  end

  // valid bits and bypass flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      byp_r   <= 1'b0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        byp_r   <= wr.en && (wr.addr == rd_addr);
        vld_q_r <= vld_r[rd_addr];
      end
    end
  end

  // same-cycle write wins over the stale array word
  assign rd_data = byp_r ? byp_data_r : (vld_q_r ? mem_q_r : dflt_r);

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr.en && wr.addr == rd_addr) |=> (rd_data == $past(wr.data)))
    else $error("store read missed a same-cycle write");

endmodule

/* design/gpr_exec.sv */
// gpr_exec: execute stage with pin levels, pending flags and the result register
// depends on gpr_pkg and gpr_if; drives store writes back to gpr_store
module gpr_exec #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  gpr_pkg::item_t              s1_item,
  input  logic [gpr_pkg::DATA_W-1:0]  store_word,
  output logic                        take,
  output gpr_pkg::store_wr_t          st_wr,
  gpr_cfg_if.sink                     cfg,
  gpr_out_if.source                   out
);

  logic [gpr_pkg::DATA_W-1:0] pin_r   [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] flg_r   [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] pin_nxt [NUM_PORTS];
  logic [gpr_pkg::DATA_W-1:0] flg_nxt [NUM_PORTS];

  logic                       out_valid_r;
  logic [gpr_pkg::DATA_W-1:0] read_data_r;
  logic [3:0]                 irq_r;
  logic                       changed_r;

  logic [gpr_pkg::DATA_W-1:0] read_data_nxt;
  logic [3:0]                 irq_nxt;
  logic                       changed_nxt;

  logic [7:0]                 rg;
  logic [4:0]                 shamt;
  logic                       in_win;
  logic [gpr_pkg::DATA_W-1:0] bus_pin;
  logic [gpr_pkg::DATA_W-1:0] bus_flg;
  logic [gpr_pkg::DATA_W-1:0] item_pin;
  logic                       item_ok;
  logic [gpr_pkg::DATA_W-1:0] rdv;
  logic [gpr_pkg::DATA_W-1:0] wmask;
  logic [gpr_pkg::DATA_W-1:0] lanev;
  logic [gpr_pkg::DATA_W-1:0] new_pin;
  logic [gpr_pkg::DATA_W-1:0] changed;

  assign cfg.ready = 1'b1;
  assign take      = s1_valid && (!out_valid_r || out.ready);

  // address decode and per-port selection
  always_comb begin
    rg       = gpr_pkg::reg_of(s1_item.offset);
    shamt    = {s1_item.offset[1:0], 3'b000};
    in_win   = s1_item.offset < gpr_pkg::WINDOW_SIZE;
    bus_pin  = '0;
    bus_flg  = '0;
    item_pin = '0;
    item_ok  = 1'b0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (s1_item.offset[9:8] == 2'(p)) begin
        bus_pin = pin_r[p];
        bus_flg = flg_r[p];
      end
      if (s1_item.port == 2'(p)) begin
        item_pin = pin_r[p];
        item_ok  = 1'b1;
      end
    end
  end

  // bus read path
  always_comb begin
    rdv = store_word;
    if (rg == gpr_pkg::REG_PIN) begin
      rdv = rdv | bus_pin;
    end else if (rg == gpr_pkg::REG_FLG) begin
      rdv = rdv | bus_flg;
    end
    rdv = rdv >> shamt;
    case (s1_item.size_code)
      gpr_pkg::SIZE_BYTE: rdv = rdv & gpr_pkg::BYTE_MASK;
      gpr_pkg::SIZE_HALF: rdv = rdv & gpr_pkg::HALF_MASK;
      default:            rdv = rdv;
    endcase
    read_data_nxt = (s1_item.kind == gpr_pkg::KIND_READ && in_win) ? rdv : '0;
  end

  // bus write path: lane merge or alias set/clear of the canonical word
  always_comb begin
    case (s1_item.size_code)
      gpr_pkg::SIZE_BYTE: begin
        wmask = gpr_pkg::BYTE_MASK << shamt;
        lanev = (s1_item.write_data << shamt) & wmask;
      end
      gpr_pkg::SIZE_HALF: begin
        wmask = gpr_pkg::HALF_MASK << shamt;
        lanev = (s1_item.write_data << shamt) & wmask;
      end
      default: begin
        wmask = gpr_pkg::ALL_ONES;
        lanev = s1_item.write_data;
      end
    endcase
    st_wr.en = take && s1_item.kind == gpr_pkg::KIND_WRITE && in_win;
    if (gpr_pkg::is_alias(s1_item.offset)) begin
      st_wr.addr = gpr_pkg::canon_addr(s1_item.offset);
      st_wr.data = (rg[3:0] == gpr_pkg::ALIAS_SET_NIB) ? (store_word | lanev)
                                                        : (store_word & ~lanev);
    end else begin
      st_wr.addr = gpr_pkg::word_addr(s1_item.offset);
      st_wr.data = (store_word & ~wmask) | lanev;
    end
  end

  // pin change, flag raise, flag clear and configuration loads
  always_comb begin
    new_pin     = s1_item.level_high ? (item_pin | s1_item.pin_mask)
                                     : (item_pin & ~s1_item.pin_mask);
    changed     = item_pin ^ new_pin;
    changed_nxt = item_ok && s1_item.kind == gpr_pkg::KIND_PIN && (|changed);
    irq_nxt     = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      pin_nxt[p] = pin_r[p];
      flg_nxt[p] = flg_r[p];
      if (take && s1_item.port == 2'(p)) begin
        if (s1_item.kind == gpr_pkg::KIND_PIN) begin
          pin_nxt[p] = new_pin;
          if (s1_item.flag_on_change) begin
            flg_nxt[p] = flg_r[p] | changed;
          end
        end else if (s1_item.kind == gpr_pkg::KIND_FLAG) begin
          flg_nxt[p] = flg_r[p] | s1_item.pin_mask;
        end
      end
      if (st_wr.en && rg == gpr_pkg::REG_DATS && s1_item.offset[9:8] == 2'(p)) begin
        flg_nxt[p] = flg_r[p] & ~lanev;
      end
      if (cfg.valid && cfg.index == 2'(p)) begin
        pin_nxt[p] = cfg.data;
      end
      irq_nxt[p] = |flg_nxt[p];
    end
  end

  // port state
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (!rst_n) begin
        pin_r[p] <= '0;
        flg_r[p] <= '0;
      end else begin
        pin_r[p] <= pin_nxt[p];
        flg_r[p] <= flg_nxt[p];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out.ready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      read_data_r <= read_data_nxt;
      irq_r       <= irq_nxt;
      changed_r   <= changed_nxt;
    end
  end

  assign out.valid         = out_valid_r;
  assign out.read_data     = read_data_r;
  assign out.irq_lines     = irq_r;
  assign out.level_changed = changed_r;

  a_wr_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> (take && s1_item.kind == gpr_pkg::KIND_WRITE))
    else $error("store written without a committed write request");

  a_irq_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out.irq_lines[0] == (|flg_r[0])))
    else $error("irq line does not match pending flags");

endmodule

/* design/gpio_port_register_block.sv */
// gpio_port_register_block: top level, request register, store and execute stage
// depends on gpr_pkg, gpr_if, gpr_store and gpr_exec
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid / ready  | kind, offset, size_code, write_data, port, pin_mask,
//          |     |                | level_high, flag_on_change
//  out_ch  | out | valid / ready  | read_data, irq_lines, level_changed
//  cfg_ch  | in  | valid / ready  | index, data (reset level of one port)
//
// one request per cycle while results are not stalled; the store read is registered
// with the request, then the execute stage commits and registers the result.
// the read-modify-write path is bounded by the one store read port and one write port,
// with a same-cycle bypass so back-to-back requests to one word see fresh data.
// reset is synchronous and clears pin levels, flags and valid bits.
// a stalled result holds the execute stage, which in turn holds the request.
module gpio_port_register_block #(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  gpr_in_if.sink     in_ch,
  gpr_out_if.source  out_ch,
  gpr_cfg_if.sink    cfg_ch
);

  logic                       s1_valid_r;
  gpr_pkg::item_t             s1_item_r;
  gpr_pkg::item_t             in_item;
  logic                       take;
  logic                       accept;
  logic [gpr_pkg::DATA_W-1:0] store_word;
  gpr_pkg::store_wr_t         st_wr;

  // request payload
  always_comb begin
    in_item.kind           = gpr_pkg::kind_t'(in_ch.kind);
    in_item.offset         = in_ch.offset;
    in_item.size_code      = in_ch.size_code;
    in_item.write_data     = in_ch.write_data;
    in_item.port           = in_ch.port;
    in_item.pin_mask       = in_ch.pin_mask;
    in_item.level_high     = in_ch.level_high;
    in_item.flag_on_change = in_ch.flag_on_change;
  end

  assign in_ch.ready = !s1_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  gpr_store #(
    .NUM_PORTS (NUM_PORTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (gpr_pkg::store_addr(in_item.kind, in_item.offset)),
    .wr      (st_wr),
    .rd_data (store_word)
  );

  gpr_exec #(
    .NUM_PORTS (NUM_PORTS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_item    (s1_item_r),
    .store_word (store_word),
    .take       (take),
    .st_wr      (st_wr),
    .cfg        (cfg_ch),
    .out        (out_ch)
  );

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("held request lost or changed");

endmodule

/* bench/tb.sv */
// tb: self-checking bench for the gpio port register block, random and directed requests
// depends on gpr_pkg, gpr_if and gpio_port_register_block from the design folder
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NUM_PORTS       = 4;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 113;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_THREE = 2'd3;
  localparam logic [7:0] REG_DAT    = 8'h10;
  localparam logic [7:0] REG_DATC   = 8'h18;

  // configuration register indexes
  localparam logic [1:0] CFG_LEVEL_A = 2'd0;
  localparam logic [1:0] CFG_LEVEL_B = 2'd1;
  localparam logic [1:0] CFG_LEVEL_C = 2'd2;
  localparam logic [1:0] CFG_LEVEL_D = 2'd3;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  irq_lines;
    logic        level_changed;
  } gpio_result_t;

  // shadow copy of the register block plus the queue of results still owed
  class gpio_shadow;
    logic [31:0]  words [gpr_pkg::WORDS];
    logic [31:0]  pins [gpr_pkg::MAX_PORTS];
    logic [31:0]  flags [gpr_pkg::MAX_PORTS];
    gpio_result_t due_results [$];
    int unsigned  mismatches;
    int unsigned  results_taken;

    function new();
      for (int i = 0; i < gpr_pkg::WORDS; i++) words[i] = '0;
      for (int p = 0; p < gpr_pkg::MAX_PORTS; p++) begin
        pins[p]  = '0;
        flags[p] = '0;
        if (p < NUM_PORTS) words[(p << 6) | (gpr_pkg::REG_IM >> 2)] = gpr_pkg::ALL_ONES;
      end
      mismatches    = 0;
      results_taken = 0;
    endfunction

    // a reset level write also loads the pins of that port at once
    function void load_level(logic [1:0] idx, logic [31:0] value);
      if (idx < NUM_PORTS) pins[idx] = value;
    endfunction

    function void take_request(gpr_pkg::item_t it);
      logic [11:0]  aligned;
      logic [7:0]   rg;
      logic [7:0]   idx;
      logic [7:0]   canon;
      logic [1:0]   wport;
      logic [4:0]   shift;
      logic [31:0]  value;
      logic [31:0]  mask;
      logic [31:0]  lane;
      logic [31:0]  prev;
      logic [31:0]  changed;
      gpio_result_t r;
      aligned = {it.offset[11:2], 2'b00};
      rg      = aligned[7:0];
      idx     = aligned[9:2];
      wport   = aligned[9:8];
      shift   = {it.offset[1:0], 3'b000};
      r       = '0;
      case (it.kind)
        gpr_pkg::KIND_READ: begin
          // pin levels and flags are merged into their words, then lane shift and size
          if (aligned < gpr_pkg::WINDOW_SIZE) begin
            value = words[idx];
            if (wport < NUM_PORTS) begin
              if (rg == gpr_pkg::REG_PIN) value |= pins[wport];
              else if (rg == gpr_pkg::REG_FLG) value |= flags[wport];
            end
            value = value >> shift;
            if (it.size_code == gpr_pkg::SIZE_BYTE) value &= gpr_pkg::BYTE_MASK;
            else if (it.size_code == gpr_pkg::SIZE_HALF) value &= gpr_pkg::HALF_MASK;
            r.read_data = value;
          end
        end
        gpr_pkg::KIND_WRITE: begin
          if (aligned < gpr_pkg::WINDOW_SIZE) begin
            if (it.size_code == gpr_pkg::SIZE_BYTE) mask = gpr_pkg::BYTE_MASK << shift;
            else if (it.size_code == gpr_pkg::SIZE_HALF) mask = gpr_pkg::HALF_MASK << shift;
            else begin
              mask  = gpr_pkg::ALL_ONES;
              shift = '0;
            end
            lane = (it.write_data << shift) & mask;
            words[idx] = (words[idx] & ~mask) | lane;
            // set and clear aliases act on their base word and read back as zero
            if (rg >= gpr_pkg::REG_DATS && rg <= gpr_pkg::REG_ALIAS_LAST &&
                (rg[3:0] == gpr_pkg::ALIAS_SET_NIB || rg[3:0] == gpr_pkg::ALIAS_CLR_NIB))
            begin
              canon = {wport, rg[7:4], 2'b00};
              if (rg[3:0] == gpr_pkg::ALIAS_SET_NIB) words[canon] |= lane;
              else words[canon] &= ~lane;
              if (rg == gpr_pkg::REG_DATS && wport < NUM_PORTS) flags[wport] &= ~lane;
              words[idx] = '0;
            end
          end
        end
        gpr_pkg::KIND_PIN: begin
          if (it.port < NUM_PORTS && it.pin_mask != '0) begin
            prev = pins[it.port];
            if (it.level_high) pins[it.port] |= it.pin_mask;
            else pins[it.port] &= ~it.pin_mask;
            changed = prev ^ pins[it.port];
            if (changed != '0) begin
              r.level_changed = 1'b1;
              if (it.flag_on_change) flags[it.port] |= changed;
            end
          end
        end
        gpr_pkg::KIND_FLAG: begin
          if (it.port < NUM_PORTS && it.pin_mask != '0) flags[it.port] |= it.pin_mask;
        end
        default: ;
      endcase
      for (int p = 0; p < gpr_pkg::MAX_PORTS; p++) begin
        if (p < NUM_PORTS && flags[p] != '0) r.irq_lines[p] = 1'b1;
      end
      due_results.push_back(r);
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) flag_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void match_result(logic [31:0] rd, logic [3:0] irq, logic chg);
      gpio_result_t want;
      results_taken++;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result read_data %h irq_lines %h changed %b",
                                rd, irq, chg));
        return;
      end
      want = due_results.pop_front();
      check_field("read_data", want.read_data, rd);
      check_field("irq_lines", 32'(want.irq_lines), 32'(irq));
      check_field("level_changed", 32'(want.level_changed), 32'(chg));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gpr_in_if  in_ch ();
  gpr_out_if out_ch ();
  gpr_cfg_if cfg_ch ();

  gpio_port_register_block #(.NUM_PORTS(NUM_PORTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gpio_shadow     shadow = new();
  gpr_pkg::item_t seen_req;
  int unsigned    reqs_sent;
  int unsigned    quiet_cycles;
  bit             gaps_on;
  bit             stall_on;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic gpr_pkg::item_t make_req(gpr_pkg::kind_t k, logic [11:0] ofs,
                                              logic [1:0] sz, logic [31:0] data,
                                              logic [1:0] p, logic [31:0] mask,
                                              logic hi, logic lat);
    gpr_pkg::item_t it;
    it.kind           = k;
    it.offset         = ofs;
    it.size_code      = sz;
    it.write_data     = data;
    it.port           = p;
    it.pin_mask       = mask;
    it.level_high     = hi;
    it.flag_on_change = lat;
    return it;
  endfunction

  function automatic gpr_pkg::item_t random_request();
    gpr_pkg::item_t it;
    logic [7:0]     rg;
    logic [1:0]     lane;
    it.kind           = gpr_pkg::kind_t'($urandom_range(0, 3));
    it.size_code      = 2'($urandom_range(0, 3));
    it.write_data     = $urandom;
    it.port           = 2'($urandom_range(0, 3));
    it.level_high     = 1'($urandom_range(0, 1));
    it.flag_on_change = 1'($urandom_range(0, 1));
    // masks: mostly sparse so pins keep toggling, sometimes empty or full
    case ($urandom_range(0, 5))
      0:       it.pin_mask = '0;
      1:       it.pin_mask = gpr_pkg::ALL_ONES;
      2, 3:    it.pin_mask = 32'h1 << $urandom_range(0, 31);
      default: it.pin_mask = $urandom & $urandom;
    endcase
    // offsets: mostly the live registers of some port, some anywhere
    lane = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'b00;
    case ($urandom_range(0, 9))
      8: it.offset = 12'($urandom);
      9: it.offset = 12'($urandom_range(0, 12'h3ff));
      default: begin
        case ($urandom_range(0, 9))
          0:       rg = gpr_pkg::REG_PIN;
          1:       rg = REG_DAT;
          2:       rg = gpr_pkg::REG_DATS;
          3:       rg = REG_DATC;
          4:       rg = gpr_pkg::REG_IM;
          5:       rg = gpr_pkg::REG_FLG;
          6:       rg = 8'h24;
          7:       rg = gpr_pkg::REG_ALIAS_LAST;
          8:       rg = 8'h44;
          default: rg = 8'($urandom_range(0, 255));
        endcase
        it.offset = {2'b00, 2'($urandom_range(0, 3)), rg[7:2], lane};
      end
    endcase
    // flag clearing through DATS keeps the irq lines moving
    if (it.kind == gpr_pkg::KIND_WRITE && $urandom_range(0, 3) == 0) begin
      it.offset     = {2'b00, it.port, gpr_pkg::REG_DATS[7:2], 2'b00};
      it.size_code  = SIZE_WORD;
      it.write_data = $urandom | $urandom;
    end
    return it;
  endfunction

  // one request, held until taken
  task automatic send_req(input gpr_pkg::item_t it);
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= it.kind;
    in_ch.offset         <= it.offset;
    in_ch.size_code      <= it.size_code;
    in_ch.write_data     <= it.write_data;
    in_ch.port           <= it.port;
    in_ch.pin_mask       <= it.pin_mask;
    in_ch.level_high     <= it.level_high;
    in_ch.flag_on_change <= it.flag_on_change;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    reqs_sent++;
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (shadow.results_taken < reqs_sent) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic load_levels(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d);
    cfg_write(CFG_LEVEL_A, a);
    cfg_write(CFG_LEVEL_B, b);
    cfg_write(CFG_LEVEL_C, c);
    cfg_write(CFG_LEVEL_D, d);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stall bursts while enabled
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: feed the shadow, check results, watchdog on quiet cycles
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_ch.valid && cfg_ch.ready) shadow.load_level(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        seen_req.kind           = gpr_pkg::kind_t'(in_ch.kind);
        seen_req.offset         = in_ch.offset;
        seen_req.size_code      = in_ch.size_code;
        seen_req.write_data     = in_ch.write_data;
        seen_req.port           = in_ch.port;
        seen_req.pin_mask       = in_ch.pin_mask;
        seen_req.level_high     = in_ch.level_high;
        seen_req.flag_on_change = in_ch.flag_on_change;
        shadow.take_request(seen_req);
      end
      if (out_ch.valid && out_ch.ready)
        shadow.match_result(out_ch.read_data, out_ch.irq_lines, out_ch.level_changed);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    reqs_sent    = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b0;
    stall_on     = 1'b1;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.kind           <= gpr_pkg::KIND_READ;
    in_ch.offset         <= '0;
    in_ch.size_code      <= gpr_pkg::SIZE_BYTE;
    in_ch.write_data     <= '0;
    in_ch.port           <= '0;
    in_ch.pin_mask       <= '0;
    in_ch.level_high     <= 1'b0;
    in_ch.flag_on_change <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_LEVEL_A;
    cfg_ch.data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    load_levels(32'h0, gpr_pkg::ALL_ONES, 32'h5a5a_00ff, $urandom);

    // directed: pin and flag words with lanes
    send_req(make_req(gpr_pkg::KIND_READ, 12'h000, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h100, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h201, gpr_pkg::SIZE_BYTE, '0, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h202, gpr_pkg::SIZE_HALF, '0, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_PIN, 12'h000, SIZE_WORD, '0, 2'd0, gpr_pkg::ALL_ONES,
                      1'b1, 1'b1));
    send_req(make_req(gpr_pkg::KIND_PIN, 12'h000, SIZE_WORD, '0, 2'd0, gpr_pkg::ALL_ONES,
                      1'b1, 1'b1));
    send_req(make_req(gpr_pkg::KIND_PIN, 12'h000, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b1));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h083, gpr_pkg::SIZE_BYTE, '0, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_FLAG, 12'h000, SIZE_WORD, '0, 2'd3, 32'h8000_0001,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_FLAG, 12'h000, SIZE_WORD, '0, 2'd2, '0, 1'b0, 1'b0));
    // set and clear aliases, DATS drops flags
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h014, SIZE_WORD, gpr_pkg::ALL_ONES, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h014, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h01a, gpr_pkg::SIZE_HALF, 32'hffff, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h010, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h314, gpr_pkg::SIZE_BYTE, 32'h01, 2'd0, '0,
                      1'b0, 1'b0));
    // word with lane bits, halfword in the top lane, size code three
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h043, SIZE_WORD, 32'hdead_beef, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h043, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h047, gpr_pkg::SIZE_HALF, 32'hffff_abcd,
                      2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h047, gpr_pkg::SIZE_HALF, '0, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'h049, SIZE_THREE, 32'h1234_5678, 2'd0, '0,
                      1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h049, SIZE_THREE, '0, 2'd0, '0, 1'b0, 1'b0));
    // above the store window, mask word reset value
    send_req(make_req(gpr_pkg::KIND_WRITE, 12'hfff, gpr_pkg::SIZE_BYTE, gpr_pkg::ALL_ONES,
                      2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h400, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_READ, 12'h320, SIZE_WORD, '0, 2'd0, '0, 1'b0, 1'b0));
    send_req(make_req(gpr_pkg::KIND_PIN, 12'h000, SIZE_WORD, '0, 2'd1, 32'h0000_ffff,
                      1'b0, 1'b1));

    // random phases, each starting from a drained block with new reset levels
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0:       load_levels(gpr_pkg::ALL_ONES, gpr_pkg::ALL_ONES, gpr_pkg::ALL_ONES,
                             gpr_pkg::ALL_ONES);
        1:       load_levels('0, '0, '0, '0);
        3:       load_levels(gpr_pkg::ALL_ONES, '0, $urandom, $urandom);
        default: load_levels($urandom, $urandom, $urandom, $urandom);
      endcase
      gaps_on  = (ph != 2) && (ph != RANDOM_PHASES - 1);
      stall_on = gaps_on;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (gaps_on && $urandom_range(0, 4) == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        send_req(random_request());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/gpr_pkg.sv
design/gpr_if.sv
design/gpr_store.sv
design/gpr_exec.sv
design/gpio_port_register_block.sv
bench/tb.sv
